FILE: rtl/core/mtep_pkg.sv
// Package for the MIDI track event parser: phase codes, result kinds and constants.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package mtep_pkg;

    localparam int KEY_COUNT_DEF       = 88;
    localparam int NOTE_INDEX_BITS_DEF = 16;
    localparam int KEY_LOW             = 21;
    localparam int KEY_HIGH            = 108;

    localparam logic [7:0] META_BYTE   = 8'hFF;
    localparam logic [7:0] END_OF_TRK  = 8'h2F;
    localparam logic [3:0] SYS_NIBBLE  = 4'hF;
    localparam logic [3:0] NOTE_ON     = 4'h9;
    localparam logic [3:0] NOTE_OFF    = 4'h8;
    localparam logic [3:0] PROG_CHANGE = 4'hC;
    localparam logic [3:0] CHAN_PRESS  = 4'hD;

    typedef enum logic [3:0] {
        PH_DELTA, PH_TYPE, PH_META_TYPE, PH_META_LEN, PH_SYS_LEN,
        PH_SKIP, PH_DATA1, PH_DATA2, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_START = 2'd0, KIND_LENGTH = 2'd1, KIND_END_MARK = 2'd2, KIND_END_BARE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_READ, ST_EMIT1, ST_EMIT2, ST_CLEAR
    } ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/mtep_divider.sv
// Iterative 32-by-16 bit restoring divider, one quotient bit per cycle.
// Depends on mtep_pkg for nothing but house consistency of imports.
`default_nettype none
module mtep_divider
    import mtep_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             busy,
    output logic [31:0]      quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [16:0] trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg[15:0], quo_reg[31]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = (divisor == 16'd0) ? 16'd1 : divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = (cnt_reg != 6'd0);
    assign quotient = quo_reg;
endmodule
`default_nettype wire

FILE: rtl/core/mtep_key_store.sv
// Per-key note store: open flags in flip-flops, note number and start time in a
// synchronous memory with a registered read port. Depends on mtep_pkg.
`default_nettype none
module mtep_key_store
    import mtep_pkg::*;
#(
    parameter int KEY_COUNT       = KEY_COUNT_DEF,
    parameter int NOTE_INDEX_BITS = NOTE_INDEX_BITS_DEF,
    localparam int KW             = $clog2(KEY_COUNT)
)(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [KW-1:0]              rd_key,
    output logic [NOTE_INDEX_BITS-1:0]      rd_note,
    output logic [31:0]                     rd_time,
    output logic                            rd_open,
    input  wire logic                       wr_en,
    input  wire logic [KW-1:0]              wr_key,
    input  wire logic [NOTE_INDEX_BITS-1:0] wr_note,
    input  wire logic [31:0]                wr_time,
    input  wire logic                       close_en,
    input  wire logic                       clear_all
);
    logic [NOTE_INDEX_BITS+31:0] mem [KEY_COUNT];
    logic [NOTE_INDEX_BITS+31:0] rdata_reg;
    logic [KEY_COUNT-1:0]        open_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_key] <= {wr_note, wr_time};
        rdata_reg <= mem[rd_key];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= '0;
        else if (clear_all)
            open_reg <= '0;
        else if (wr_en)
            open_reg[wr_key] <= 1'b1;
        else if (close_en)
            open_reg[wr_key] <= 1'b0;
    end

    assign rd_open = open_reg[rd_key];
    assign rd_note = rdata_reg[NOTE_INDEX_BITS+31:32];
    assign rd_time = rdata_reg[31:0];
endmodule
`default_nettype wire

FILE: rtl/core/midi_track_event_parser_core.sv
// Top level of the MIDI track event parser: byte parser, control sequencer and
// output register. Depends on mtep_pkg, mtep_divider and mtep_key_store.
//
//  channel  | direction | handshake          | payload
//  s_axis   | in        | tvalid/tready      | tdata = data_byte; tlast = last_in_chunk
//  m_axis   | out       | tvalid/tready      | tdata/tuser/tlast as listed at the ports
//  cfg      | in        | cfg_valid/ready    | cfg_data = time_divisor
//
// A byte that completes a delta holds the parser while the 32-step divider runs.
// The second data byte of a note-on or note-off passes through acceptance, the key
// memory read and the result beat. Other bytes are taken in the idle state, and the
// final byte of a chunk adds the chunk-end clear. A result waits in the output
// register; the parser takes no further byte until it is taken.
// Reset is asynchronous; open-key flags clear at once, at an end-of-track event and at each chunk end.
`default_nettype none
module midi_track_event_parser_core
    import mtep_pkg::*;
#(
    parameter int KEY_COUNT       = KEY_COUNT_DEF,
    parameter int NOTE_INDEX_BITS = NOTE_INDEX_BITS_DEF
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // last_in_chunk
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // note_index[NIB-1:0], key_number[6:0], velocity[6:0], event_time[31:0],
    // note_length[31:0], zero fill to bytes
    output logic [((NOTE_INDEX_BITS+78+7)/8)*8-1:0] m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // event_kind
    output logic             m_axis_tlast,   // last_of_run
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data        // time_divisor
);
    localparam int KW  = $clog2(KEY_COUNT);
    localparam int NIB = NOTE_INDEX_BITS;
    localparam int DW  = ((NIB + 78 + 7) / 8) * 8;
    localparam logic [NIB-1:0] NOTE_MAX = '1;

    ctl_t ctl_reg, ctl_next;
    phase_t ph_reg, ph_next;
    logic [31:0] vlq_reg, vlq_next, tick_reg, tick_next, cur_reg, cur_next;
    logic [31:0] skip_reg, skip_next;
    logic [7:0]  stat_reg, stat_next, fdb_reg, fdb_next, vel_reg, vel_next;
    logic [NIB-1:0] cnt_reg, cnt_next;
    logic        last_reg, last_next;
    logic [15:0] div_reg;

    logic        ov_reg, ov_next;
    logic [1:0]  okind_reg, okind_next;
    logic [NIB-1:0] oidx_reg, oidx_next;
    logic [6:0]  okey_reg, okey_next, ovel_reg, ovel_next;
    logic [31:0] otime_reg, otime_next, olen_reg, olen_next;
    logic        olast_reg, olast_next;

    logic        div_start, div_busy;
    logic [31:0] div_q, vlq_shift;
    logic        key_ok;
    logic [7:0]  key_off;
    logic [KW-1:0] key_idx;
    logic [NIB-1:0] rd_note;
    logic [31:0] rd_time;
    logic        rd_open, wr_en, close_en, clear_all;
    logic        in_acc, out_free;

    assign out_free      = !ov_reg || m_axis_tready;
    assign s_axis_tready = (ctl_reg == ST_IDLE) && out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign vlq_shift     = {vlq_reg[24:0], s_axis_tdata[6:0]};
    assign key_off       = fdb_reg - 8'(KEY_LOW);
    assign key_ok        = (fdb_reg >= 8'(KEY_LOW)) && (fdb_reg <= 8'(KEY_HIGH))
                           && (32'(key_off) < 32'(KEY_COUNT));
    assign key_idx       = key_off[KW-1:0];

    mtep_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(tick_next),
        .divisor(div_reg), .busy(div_busy), .quotient(div_q)
    );

    mtep_key_store #(.KEY_COUNT(KEY_COUNT), .NOTE_INDEX_BITS(NIB)) u_keys (
        .clk(clk), .rst_n(rst_n), .rd_key(key_idx), .rd_note(rd_note),
        .rd_time(rd_time), .rd_open(rd_open), .wr_en(wr_en), .wr_key(key_idx),
        .wr_note(cnt_reg), .wr_time(cur_reg), .close_en(close_en),
        .clear_all(clear_all)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_reg <= 16'd1;
        else if (cfg_valid)
            div_reg <= cfg_data;
    end

    // Next state of the sequencer.
    always_comb
    begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    if (ph_reg == PH_DELTA && !s_axis_tdata[7])
                        ctl_next = ST_DIV;
                    else if (ph_reg == PH_DATA2)
                        ctl_next = ST_READ;
                    else if (s_axis_tlast)
                        ctl_next = ST_CLEAR;
                end
            ST_DIV:
                if (!div_busy)
                    ctl_next = last_reg ? ST_CLEAR : ST_IDLE;
            ST_READ:
                ctl_next = ST_EMIT1;
            ST_EMIT1:
                if (out_free)
                    ctl_next = last_reg ? ST_CLEAR : ST_IDLE;
            ST_CLEAR:
                if (out_free)
                    ctl_next = ST_IDLE;
            default:
                ctl_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs of the sequencer.
    always_comb
    begin
        ph_next = ph_reg; vlq_next = vlq_reg; tick_next = tick_reg;
        cur_next = cur_reg; skip_next = skip_reg; stat_next = stat_reg;
        fdb_next = fdb_reg; vel_next = vel_reg; cnt_next = cnt_reg;
        last_next = last_reg;
        ov_next = ov_reg && !m_axis_tready; okind_next = okind_reg;
        oidx_next = oidx_reg; okey_next = okey_reg; ovel_next = ovel_reg;
        otime_next = otime_reg; olen_next = olen_reg; olast_next = olast_reg;
        div_start = 1'b0; wr_en = 1'b0; close_en = 1'b0; clear_all = 1'b0;
        unique case (ctl_reg)
            ST_IDLE:
                if (in_acc)
                begin
                    last_next = s_axis_tlast;
                    unique case (ph_reg) inside
                        PH_DELTA:
                        begin
                            vlq_next = vlq_shift;
                            if (!s_axis_tdata[7])
                            begin
                                tick_next = tick_reg + vlq_shift;
                                vlq_next  = '0;
                                ph_next   = PH_TYPE;
                            end
                        end
                        PH_TYPE:
                        begin
                            stat_next = s_axis_tdata;
                            if (s_axis_tdata == META_BYTE)
                                ph_next = PH_META_TYPE;
                            else if (s_axis_tdata[7:4] == SYS_NIBBLE)
                                ph_next = PH_SYS_LEN;
                            else if (s_axis_tdata[7:4] == NOTE_ON
                                     || s_axis_tdata[7:4] == NOTE_OFF)
                                ph_next = PH_DATA1;
                            else if (s_axis_tdata[7:4] == PROG_CHANGE
                                     || s_axis_tdata[7:4] == CHAN_PRESS)
                            begin
                                skip_next = 32'd1; ph_next = PH_SKIP;
                            end
                            else
                            begin
                                skip_next = 32'd2; ph_next = PH_SKIP;
                            end
                        end
                        PH_META_TYPE:
                        begin
                            fdb_next = s_axis_tdata; vlq_next = '0; ph_next = PH_META_LEN;
                        end
                        PH_META_LEN, PH_SYS_LEN:
                        begin
                            vlq_next = vlq_shift;
                            if (!s_axis_tdata[7])
                            begin
                                vlq_next = '0;
                                if (ph_reg == PH_META_LEN && fdb_reg == END_OF_TRK)
                                begin
                                    ov_next = 1'b1; okind_next = KIND_END_MARK;
                                    oidx_next = cnt_reg; okey_next = '0; ovel_next = '0;
                                    otime_next = cur_reg; olen_next = '0;
                                    olast_next = 1'b1;
                                    ph_next = PH_DONE; tick_next = '0; cur_next = '0;
                                    skip_next = '0; stat_next = '0; fdb_next = '0;
                                    cnt_next = '0; clear_all = 1'b1;
                                    if (s_axis_tlast)
                                        last_next = 1'b0;
                                end
                                else
                                begin
                                    skip_next = vlq_shift;
                                    ph_next = (vlq_shift == 32'd0) ? PH_DELTA : PH_SKIP;
                                end
                            end
                        end
                        PH_SKIP:
                        begin
                            skip_next = skip_reg - 32'd1;
                            if (skip_reg == 32'd1)
                                ph_next = PH_DELTA;
                        end
                        PH_DATA1:
                        begin
                            fdb_next = s_axis_tdata; ph_next = PH_DATA2;
                        end
                        PH_DATA2:
                        begin
                            vel_next = s_axis_tdata; ph_next = PH_DELTA;
                        end
                        default: ;
                    endcase
                    if (s_axis_tlast && ph_reg == PH_DONE)
                        last_next = 1'b0;
                end
            ST_DIV:
                if (!div_busy)
                    cur_next = div_q;
            ST_EMIT1:
                if (out_free)
                begin
                    if (key_ok && stat_reg[7:4] == NOTE_ON && !rd_open)
                    begin
                        wr_en = 1'b1;
                        ov_next = 1'b1; okind_next = KIND_START; oidx_next = cnt_reg;
                        okey_next = key_off[6:0]; ovel_next = vel_reg[6:0];
                        otime_next = cur_reg; olen_next = '0; olast_next = !last_reg;
                        if (cnt_reg != NOTE_MAX)
                            cnt_next = cnt_reg + 1'b1;
                    end
                    else if (key_ok && stat_reg[7:4] != NOTE_ON && rd_open)
                    begin
                        close_en = 1'b1;
                        ov_next = 1'b1; okind_next = KIND_LENGTH; oidx_next = rd_note;
                        okey_next = key_off[6:0]; ovel_next = '0;
                        otime_next = rd_time; olen_next = cur_reg - rd_time;
                        olast_next = !last_reg;
                    end
                end
            ST_CLEAR:
                if (out_free)
                begin
                    if (last_reg)
                    begin
                        ov_next = 1'b1; okind_next = KIND_END_BARE; oidx_next = cnt_reg;
                        okey_next = '0; ovel_next = '0; otime_next = cur_reg;
                        olen_next = '0; olast_next = 1'b1;
                    end
                    ph_next = PH_DELTA; vlq_next = '0; tick_next = '0; cur_next = '0;
                    skip_next = '0; stat_next = '0; fdb_next = '0; cnt_next = '0;
                    last_next = 1'b0; clear_all = 1'b1;
                end
            default: ;
        endcase
        if (ctl_reg == ST_IDLE && ctl_next == ST_DIV)
            div_start = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= ST_IDLE; ph_reg <= PH_DELTA; vlq_reg <= '0; tick_reg <= '0;
            cur_reg <= '0; skip_reg <= '0; stat_reg <= '0; fdb_reg <= '0;
            cnt_reg <= '0; last_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            ctl_reg <= ctl_next; ph_reg <= ph_next; vlq_reg <= vlq_next;
            tick_reg <= tick_next; cur_reg <= cur_next; skip_reg <= skip_next;
            stat_reg <= stat_next; fdb_reg <= fdb_next; cnt_reg <= cnt_next;
            last_reg <= last_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vel_reg <= vel_next; okind_reg <= okind_next; oidx_reg <= oidx_next;
        okey_reg <= okey_next; ovel_reg <= ovel_next; otime_reg <= otime_next;
        olen_reg <= olen_next; olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = DW'({olen_reg, otime_reg, ovel_reg, okey_reg, oidx_reg});
endmodule
`default_nettype wire
